// ===== rtl/ppe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared constants, register codes, types and the output clipping function
// of the pair potential energy unit.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int SQ_STAGES  = 16;  // two root bits per stage
  localparam int DIV_STAGES = 17;  // four quotient bits per stage
  localparam int POW_STEPS  = 31;  // largest exponent the 5-bit register holds

  localparam int P_ROOT = SQ_STAGES;
  localparam int P_QUO  = P_ROOT + DIV_STAGES;
  localparam int P_PW   = P_QUO + 2 * POW_STEPS;
  localparam int P_LAST = P_PW + 8;

  localparam logic [47:0] E_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] E_MIN = 48'h8000_0000_0000;

  typedef enum logic [2:0] {
    REG_ALPHA     = 3'd0,
    REG_TWO_ROOT  = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_OFFSET_EN = 3'd3,
    REG_LAMBDA_EN = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [47:0] val;
    logic               sat;
  } clip_t;

  // Fields that travel alongside the arithmetic units.
  typedef struct packed {
    logic [47:0]        d2;
    logic [31:0]        sg;
    logic [31:0]        off;
    logic               eneg;
    logic [31:0]        emag;
    logic [30:0]        lam;
    logic signed [36:0] rm;
    logic [32:0]        tmag;
    logic               tneg;
    logic               hard;
    logic               le;
  } side_t;

  // Signed magnitude to the 48-bit output range, with saturation flag.
  function automatic clip_t clip_mag(input logic neg, input logic [95:0] mag);
    clip_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > {48'd0, E_MIN}) begin
        r.sat = 1'b1;
        r.val = $signed(E_MIN);
      end else begin
        r.val = $signed(48'(~mag[47:0] + 48'd1));
      end
    end else begin
      if (mag > {48'd0, E_MAX}) begin
        r.sat = 1'b1;
        r.val = $signed(E_MAX);
      end else begin
        r.val = $signed(mag[47:0]);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/ppe_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_isqrt
// Pipelined integer square root of a 64-bit word, two root bits per stage.
// ----------------------------------------------------------------------------
module ppe_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x_i,
  output logic [31:0] root_o
);

  localparam int N = ppe_pkg::SQ_STAGES;

  logic [63:0] x_q    [N];
  logic [34:0] rem_q  [N];
  logic [31:0] root_q [N];
  logic [63:0] x_d    [N];
  logic [34:0] rem_d  [N];
  logic [31:0] root_d [N];

  always_comb begin
    logic [63:0] xv;
    logic [34:0] rv;
    logic [31:0] tv;
    logic [33:0] trial;
    for (int j = 0; j < N; j++) begin
      if (j == 0) begin
        xv = x_i;
        rv = '0;
        tv = '0;
      end else begin
        xv = x_q[j-1];
        rv = rem_q[j-1];
        tv = root_q[j-1];
      end
      for (int s = 0; s < 2; s++) begin
        rv    = {rv[32:0], xv[63:62]};
        trial = {tv, 2'b01};
        xv    = {xv[61:0], 2'b00};
        if (rv >= {1'b0, trial}) begin
          rv = rv - {1'b0, trial};
          tv = {tv[30:0], 1'b1};
        end else begin
          tv = {tv[30:0], 1'b0};
        end
      end
      x_d[j]    = xv;
      rem_d[j]  = rv;
      root_d[j] = tv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < N; j++) begin
        x_q[j]    <= x_d[j];
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

// ===== rtl/ppe_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_div
// Pipelined restoring divider: (num * 2^32) / den, four quotient bits a stage.
// ----------------------------------------------------------------------------
module ppe_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [32:0] num_i,
  input  logic [32:0] den_i,
  output logic [67:0] quo_o
);

  localparam int N = ppe_pkg::DIV_STAGES;

  logic [67:0] n_q   [N];
  logic [33:0] rem_q [N];
  logic [67:0] quo_q [N];
  logic [32:0] den_q [N];
  logic [67:0] n_d   [N];
  logic [33:0] rem_d [N];
  logic [67:0] quo_d [N];
  logic [32:0] den_d [N];

  always_comb begin
    logic [67:0] nv;
    logic [33:0] rv;
    logic [67:0] qv;
    logic [32:0] dv;
    for (int j = 0; j < N; j++) begin
      if (j == 0) begin
        nv = {3'b000, num_i, 32'd0};
        rv = '0;
        qv = '0;
        dv = den_i;
      end else begin
        nv = n_q[j-1];
        rv = rem_q[j-1];
        qv = quo_q[j-1];
        dv = den_q[j-1];
      end
      for (int s = 0; s < 4; s++) begin
        rv = {rv[32:0], nv[67]};
        nv = {nv[66:0], 1'b0};
        if (rv >= {1'b0, dv}) begin
          rv = rv - {1'b0, dv};
          qv = {qv[66:0], 1'b1};
        end else begin
          qv = {qv[66:0], 1'b0};
        end
      end
      n_d[j]   = nv;
      rem_d[j] = rv;
      quo_d[j] = qv;
      den_d[j] = dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < N; j++) begin
        n_q[j]   <= n_d[j];
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
        den_q[j] <= den_d[j];
      end
    end
  end

  assign quo_o = quo_q[N-1];

endmodule

// ===== rtl/pair_potential_energy_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_potential_energy_unit
// Generalised Lennard-Jones pair energy, one particle pair per item.
// ----------------------------------------------------------------------------
// The unit is a fully pipelined datapath of 104 register stages: it accepts
// one item in every cycle in which the pipe advances and returns the results
// in order. The length is set by the square root (16 stages), the divider
// (17 stages) and the chain of 31 power product steps (two stages each),
// followed by the energy, clipping and lambda stages. The whole pipe
// advances together: when the output item is not taken, every stage holds,
// so nothing is lost or repeated. Configuration is written through its own
// channel, which is always ready; write it only while no item is in flight.
// ----------------------------------------------------------------------------
module pair_potential_energy_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write channel.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0: dist_squared[47:0], pair_sigma[79:48],
  // pair_epsilon[111:80], pair_offset[143:112], pair_lambda[174:144], zero.
  input  logic [175:0] s_axis_tdata,
  // Output stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // Fields from bit 0: pair_energy[47:0].
  output logic [47:0]  m_axis_tdata,
  // Fields from bit 0: hard_core[0], saturated[1].
  output logic [1:0]   m_axis_tuser
);

  localparam int P_ROOT    = ppe_pkg::P_ROOT;
  localparam int P_PW      = ppe_pkg::P_PW;
  localparam int P_LAST    = ppe_pkg::P_LAST;
  localparam int POW_STEPS = ppe_pkg::POW_STEPS;

  // Registers of one power product step: partial products, then the sum.
  typedef struct packed {
    logic [63:0] q;
    logic [63:0] pw;
    logic        povf;
    logic        act;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pa_t;

  typedef struct packed {
    logic [63:0] q;
    logic [63:0] pw;
    logic        povf;
  } pb_t;

  // Configuration registers.
  logic [4:0]  cfg_alpha_q;
  logic [31:0] cfg_tra_q;
  logic [31:0] cfg_thr_q;
  logic        cfg_offen_q;
  logic        cfg_lamen_q;

  // The whole pipe moves when the output stage is empty or being taken.
  logic en;
  logic [P_LAST:0] vld_q;

  ppe_pkg::side_t side_q [P_LAST];
  ppe_pkg::side_t side_d [P_LAST];

  assign en            = !vld_q[P_LAST] || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_alpha_q <= 5'd6;
      cfg_tra_q   <= 32'd1205234447;
      cfg_thr_q   <= '0;
      cfg_offen_q <= 1'b0;
      cfg_lamen_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ppe_pkg::REG_ALPHA:     cfg_alpha_q <= cfg_data_i[4:0];
        ppe_pkg::REG_TWO_ROOT:  cfg_tra_q   <= cfg_data_i;
        ppe_pkg::REG_THRESHOLD: cfg_thr_q   <= cfg_data_i;
        ppe_pkg::REG_OFFSET_EN: cfg_offen_q <= cfg_data_i[0];
        ppe_pkg::REG_LAMBDA_EN: cfg_lamen_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[P_LAST-1:0], s_axis_tvalid};
    end
  end

  // Early products: sigma squared for the hard-core test, the position of
  // the minimum and the lambda shift term.
  logic [63:0] sgsq_q;
  logic [64:0] rmp_q;
  logic [61:0] tprod_q;
  logic        diffneg_q;
  logic [63:0] tha_q;
  logic [63:0] thb_q;
  logic        diffneg_d;
  logic [30:0] dmag_d;

  assign diffneg_d = side_q[0].lam > 31'h4000_0000;
  assign dmag_d    = diffneg_d ? (side_q[0].lam - 31'h4000_0000)
                               : (31'h4000_0000 - side_q[0].lam);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sgsq_q    <= side_q[0].sg * side_q[0].sg;
      rmp_q     <= cfg_tra_q * ({1'b0, side_q[0].sg} + {1'b0, side_q[0].off});
      tprod_q   <= side_q[0].emag * dmag_d;
      diffneg_q <= diffneg_d;
      tha_q     <= cfg_thr_q * sgsq_q[31:0];
      thb_q     <= cfg_thr_q * sgsq_q[63:32];
    end
  end

  // Square root and divider.
  logic [31:0] root;
  logic [67:0] quo;

  ppe_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    ({side_q[0].d2, 16'd0}),
    .root_o (root)
  );

  ppe_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({1'b0, side_q[P_ROOT].sg} + {1'b0, side_q[P_ROOT].off}),
    .den_i ({1'b0, root} + {1'b0, side_q[P_ROOT].off}),
    .quo_o (quo)
  );

  // Side line: the item's fields, updated at the stages where their
  // derived values are formed.
  always_comb begin
    logic [95:0] rhs;
    side_d[0].d2   = s_axis_tdata[47:0];
    side_d[0].sg   = s_axis_tdata[79:48];
    side_d[0].eneg = s_axis_tdata[111];
    side_d[0].emag = s_axis_tdata[111] ? (~s_axis_tdata[111:80] + 32'd1)
                                       : s_axis_tdata[111:80];
    side_d[0].off  = cfg_offen_q ? s_axis_tdata[143:112] : 32'd0;
    side_d[0].lam  = s_axis_tdata[174:144];
    side_d[0].rm   = '0;
    side_d[0].tmag = '0;
    side_d[0].tneg = 1'b0;
    side_d[0].hard = 1'b0;
    side_d[0].le   = 1'b0;
    for (int k = 1; k < P_LAST; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[2].rm   = $signed({2'b00, rmp_q[64:30]}) - $signed({5'd0, side_q[1].off});
    side_d[2].tmag = {1'b0, 32'(tprod_q >> 30)};
    side_d[2].tneg = side_q[1].eneg ^ diffneg_q;
    rhs            = {32'd0, tha_q} + {thb_q, 32'd0};
    side_d[3].hard = (side_q[2].d2 == 48'd0) || ({8'd0, side_q[2].d2, 40'd0} < rhs);
    side_d[P_ROOT+1].le = $signed({5'd0, root}) <= side_q[P_ROOT].rm;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < P_LAST; k++) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  // Power chain: q^a by successive truncated products.
  pb_t pow_init;
  pa_t pa_q [POW_STEPS];
  pb_t pb_q [POW_STEPS];

  assign pow_init.q    = quo[63:0];
  assign pow_init.pw   = 64'h1_0000_0000;
  assign pow_init.povf = (quo[67:63] != 5'd0) && (cfg_alpha_q != 5'd0);

  for (genvar k = 0; k < POW_STEPS; k++) begin : g_pow
    pb_t          src;
    logic [127:0] prod;

    if (k == 0) begin : g_first
      assign src = pow_init;
    end else begin : g_next
      assign src = pb_q[k-1];
    end

    assign prod = {64'd0, pa_q[k].p00} + {32'd0, pa_q[k].p01, 32'd0}
                + {32'd0, pa_q[k].p10, 32'd0} + {pa_q[k].p11, 64'd0};

    always_ff @(posedge clk_i) begin
      if (en) begin
        pa_q[k].q    <= src.q;
        pa_q[k].pw   <= src.pw;
        pa_q[k].povf <= src.povf;
        pa_q[k].act  <= (5'(k) < cfg_alpha_q) && !src.povf;
        pa_q[k].p00  <= src.pw[31:0]  * src.q[31:0];
        pa_q[k].p01  <= src.pw[31:0]  * src.q[63:32];
        pa_q[k].p10  <= src.pw[63:32] * src.q[31:0];
        pa_q[k].p11  <= src.pw[63:32] * src.q[63:32];
        pb_q[k].q    <= pa_q[k].q;
        if (pa_q[k].act) begin
          if (prod[127:96] != 32'd0) begin
            pb_q[k].pw   <= pa_q[k].pw;
            pb_q[k].povf <= 1'b1;
          end else begin
            pb_q[k].pw   <= prod[95:32];
            pb_q[k].povf <= prod[95];
          end
        end else begin
          pb_q[k].pw   <= pa_q[k].pw;
          pb_q[k].povf <= pa_q[k].povf;
        end
      end
    end
  end

  // Energy: u = 4*eps*q^a*(q^a - 1), then clipping and lambda handling.
  logic [63:0]        pw96_q, pm96_q;
  logic               below_q [P_PW+1:P_PW+5];
  logic               povf_q  [P_PW+1:P_PW+5];
  logic [63:0]        x00_q, x01_q, x10_q, x11_q;
  logic [127:0]       x_q;
  logic [65:0]        c0_q, c1_q, c2_q, c3_q;
  logic [95:0]        mag_q;
  logic signed [47:0] u101_q, u102_q;
  logic               uflag101_q, uflag102_q;
  logic signed [49:0] sum_q;
  logic [54:0]        pl_q, ph_q;
  logic               uneg_q;
  logic signed [47:0] out_energy_q;
  logic               out_hard_q;
  logic               out_sat_q;

  logic [63:0]        pw_end;
  logic               below_d;
  logic [33:0]        m_d;
  logic [161:0]       total;
  ppe_pkg::clip_t     cu_d;
  logic [47:0]        umag_d;
  logic signed [49:0] ue_d, te_d;

  assign pw_end  = pb_q[POW_STEPS-1].pw;
  assign below_d = pw_end < 64'h1_0000_0000;
  assign m_d     = {side_q[P_PW+3].emag, 2'b00};
  assign total   = {96'd0, c0_q} + {64'd0, c1_q, 32'd0} + {32'd0, c2_q, 64'd0}
                 + {c3_q, 96'd0};
  assign umag_d  = u101_q[47] ? (~u101_q + 48'd1) : u101_q;
  assign ue_d    = {{2{u101_q[47]}}, u101_q};
  assign te_d    = $signed({17'd0, side_q[P_PW+6].tmag});

  always_comb begin
    if (povf_q[P_PW+5]) begin
      if (side_q[P_PW+5].emag == 32'd0) begin
        cu_d = '0;
      end else begin
        cu_d = ppe_pkg::clip_mag(side_q[P_PW+5].eneg, {48'd0, 48'hFFFF_FFFF_FFFF});
      end
    end else begin
      cu_d = ppe_pkg::clip_mag(side_q[P_PW+5].eneg ^ below_q[P_PW+5], mag_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw96_q      <= pw_end;
      pm96_q      <= below_d ? (64'h1_0000_0000 - pw_end) : (pw_end - 64'h1_0000_0000);
      below_q[P_PW+1] <= below_d;
      povf_q[P_PW+1]  <= pb_q[POW_STEPS-1].povf;
      for (int k = P_PW + 2; k <= P_PW + 5; k++) begin
        below_q[k] <= below_q[k-1];
        povf_q[k]  <= povf_q[k-1];
      end
      x00_q <= pw96_q[31:0]  * pm96_q[31:0];
      x01_q <= pw96_q[31:0]  * pm96_q[63:32];
      x10_q <= pw96_q[63:32] * pm96_q[31:0];
      x11_q <= pw96_q[63:32] * pm96_q[63:32];
      x_q   <= {64'd0, x00_q} + {32'd0, x01_q, 32'd0} + {32'd0, x10_q, 32'd0}
             + {x11_q, 64'd0};
      c0_q  <= m_d * x_q[31:0];
      c1_q  <= m_d * x_q[63:32];
      c2_q  <= m_d * x_q[95:64];
      c3_q  <= m_d * x_q[127:96];
      mag_q <= total[159:64];
      u101_q     <= cu_d.val;
      uflag101_q <= cu_d.sat;
      u102_q     <= u101_q;
      uflag102_q <= uflag101_q;
      uneg_q     <= u101_q[47];
      sum_q      <= side_q[P_PW+6].tneg ? (ue_d - te_d) : (ue_d + te_d);
      pl_q       <= umag_d[23:0]  * side_q[P_PW+6].lam;
      ph_q       <= umag_d[47:24] * side_q[P_PW+6].lam;
    end
  end

  // Output stage: hard core overrides, lambda selects shift or scale.
  always_ff @(posedge clk_i) begin
    logic [49:0]    sabs;
    logic [78:0]    sprod;
    ppe_pkg::clip_t c;
    if (en) begin
      sabs  = sum_q[49] ? 50'(-sum_q) : 50'(sum_q);
      sprod = {24'd0, pl_q} + {ph_q, 24'd0};
      if (side_q[P_PW+7].le) begin
        c = ppe_pkg::clip_mag(sum_q[49], {46'd0, sabs});
      end else begin
        c = ppe_pkg::clip_mag(uneg_q, {47'd0, sprod[78:30]});
      end
      if (side_q[P_PW+7].hard) begin
        out_energy_q <= '0;
        out_hard_q   <= 1'b1;
        out_sat_q    <= 1'b0;
      end else if (!cfg_lamen_q) begin
        out_energy_q <= u102_q;
        out_hard_q   <= 1'b0;
        out_sat_q    <= uflag102_q;
      end else begin
        out_energy_q <= c.val;
        out_hard_q   <= 1'b0;
        out_sat_q    <= uflag102_q | c.sat;
      end
    end
  end

  assign m_axis_tvalid = vld_q[P_LAST];
  assign m_axis_tdata  = out_energy_q;
  assign m_axis_tuser  = {out_sat_q, out_hard_q};

endmodule

// ===== tb/pair_potential_energy_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_potential_energy_unit_test
// Self-checking bench for the pair potential energy unit: a behavioural
// predictor of the fixed-point Lennard-Jones energy checks every result item.
// ----------------------------------------------------------------------------
// Stimulus runs in phases. Each phase writes the registers while the unit is
// idle, then sends directed and random pair items through the input stream.
// Both streams idle at random; one phase holds the output back for a long
// stretch so that the pipe fills and stalls its input.
// ----------------------------------------------------------------------------
module pair_potential_energy_unit_test;

  localparam int PIPE_DEPTH = 104;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [30:0] lam;
    logic [31:0] off;
    logic [31:0] eps;
    logic [31:0] sg;
    logic [47:0] d2;
  } pair_t;

  typedef struct packed {
    logic [47:0] energy;
    logic        hard;
    logic        sat;
  } energy_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  pair_potential_energy_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor copy of the registers.
  logic [4:0]  alpha_q = 5'd6;
  logic [31:0] root_q = 32'd1205234447;
  logic [31:0] thresh_q = '0;
  logic        off_en_q = 1'b0;
  logic        lam_en_q = 1'b0;

  pair_t   pending_pairs[$];
  energy_t expected_energy[$];
  int      error_count = 0;
  int      checked_count = 0;
  int      hard_count = 0;
  int      sat_count = 0;
  longint  cycle_count = 0;
  int      hold_off_cycles = 0;
  logic    hold_done = 1'b0;

  task automatic report(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Signed magnitude to the output range; sets sat on clipping.
  function automatic logic signed [63:0] clip_to_out(input logic neg, input logic [127:0] mag,
                                                     inout logic sat);
    if (neg) begin
      if (mag > 128'h8000_0000_0000) begin
        sat = 1'b1;
        return -64'sh8000_0000_0000;
      end
      return -$signed({1'b0, mag[62:0]});
    end
    if (mag > 128'h7FFF_FFFF_FFFF) begin
      sat = 1'b1;
      return 64'sh7FFF_FFFF_FFFF;
    end
    return $signed({1'b0, mag[62:0]});
  endfunction

  function automatic energy_t pair_energy(input pair_t p);
    energy_t res;
    logic        eneg, sat, below, povf, dneg, tneg, uneg;
    logic [32:0] emag;
    logic [31:0] off;
    logic [127:0] limit, prod, umag128;
    logic [63:0] r, num, den, q, pw, pm, dmag, tmag, umag;
    logic signed [63:0] u, rm, diff, sum;
    res = '0;
    sat = 1'b0;
    eneg = p.eps[31];
    emag = eneg ? 33'h1_0000_0000 - {1'b0, p.eps} : {1'b0, p.eps};
    off = off_en_q ? p.off : 32'd0;
    limit = 128'(thresh_q) * (128'(p.sg) * 128'(p.sg));
    if (p.d2 == 0 || (128'(p.d2) << 40) < limit) begin
      res.hard = 1'b1;
      return res;
    end
    r = int_sqrt(64'(p.d2) << 16);
    num = 64'(p.sg) + 64'(off);
    den = r + 64'(off);
    povf = 1'b0;
    q = 0;
    if (num / den >= 64'h8000_0000) povf = 1'b1;
    else q = 64'((128'(num) << 32) / 128'(den));
    povf = povf && alpha_q != 0;
    pw = 64'h1_0000_0000;
    for (int k = 0; k < alpha_q && !povf; k++) begin
      prod = 128'(pw) * 128'(q);
      if (prod[127:96] != 0) povf = 1'b1;
      else begin
        pw = prod[95:32];
        if (pw[63]) povf = 1'b1;
      end
    end
    if (povf) begin
      u = (emag == 0) ? 64'sd0 : clip_to_out(eneg, 128'hFFFF_FFFF_FFFF, sat);
    end else begin
      below = pw < 64'h1_0000_0000;
      pm = below ? 64'h1_0000_0000 - pw : pw - 64'h1_0000_0000;
      prod = 128'(pw) * 128'(pm);
      // Exact 4*eps*prod, magnitude truncated to Q32.16 (shift by 64).
      umag128 = 128'((256'(emag) * 4 * 256'(prod)) >> 64);
      if (umag128 > 128'h1_0000_0000_0000) umag128 = 128'h1_0000_0000_0000;
      u = (umag128 == 0) ? 64'sd0 : clip_to_out(eneg != below, umag128, sat);
    end
    if (lam_en_q) begin
      prod = 128'(root_q) * 128'(64'(p.sg) + 64'(off));
      rm = $signed(prod[93:30]) - $signed(64'(off));
      if ($signed(r) <= rm) begin
        diff = 64'sh4000_0000 - $signed(64'(p.lam));
        dneg = diff < 0;
        dmag = dneg ? -diff : diff;
        tmag = 64'((128'(emag) * 128'(dmag)) >> 30);
        tneg = eneg != dneg;
        sum = u + (tneg ? -$signed(tmag) : $signed(tmag));
        u = clip_to_out(sum < 0, 128'(sum < 0 ? -sum : sum), sat);
      end else begin
        uneg = u < 0;
        umag = uneg ? -u : u;
        u = clip_to_out(uneg, (128'(umag) * 128'(p.lam)) >> 30, sat);
      end
    end
    res.energy = u[47:0];
    res.sat = sat;
    return res;
  endfunction

  // Input driver: per-item random gap, changes at the falling edge.
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        // handshake was taken at the last rising edge
      end
    end
  end

  logic  sent_flag = 1'b0;
  pair_t in_flight;
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_energy.push_back(pair_energy(in_flight));
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !sent_flag) begin
        // still waiting for acceptance
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        in_flight = pending_pairs.pop_front();
        s_axis_tdata <= {1'b0, in_flight};
        s_axis_tvalid <= 1'b1;
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end
  // sent_flag marks that the offered item was accepted at the last edge.
  always @(posedge clk_i) sent_flag <= s_axis_tvalid && s_axis_tready;

  // Output monitor and receiver stalls.
  int recv_gap = 0;
  always @(posedge clk_i) begin
    energy_t exp_e;
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_energy.size() == 0) begin
        report("result item with no expectation");
      end else begin
        exp_e = expected_energy.pop_front();
        checked_count++;
        if (exp_e.hard) hard_count++;
        if (exp_e.sat) sat_count++;
        if (m_axis_tdata !== exp_e.energy)
          report($sformatf("pair_energy %h, expected %h", m_axis_tdata, exp_e.energy));
        if (m_axis_tuser[0] !== exp_e.hard)
          report($sformatf("hard_core %b, expected %b", m_axis_tuser[0], exp_e.hard));
        if (m_axis_tuser[1] !== exp_e.sat)
          report($sformatf("saturated %b, expected %b", m_axis_tuser[1], exp_e.sat));
      end
    end
  end

  // Receiver: one long hold once a good part of the run has been checked,
  // random gaps otherwise.
  always @(negedge clk_i) begin
    if (!hold_done && checked_count >= 800) begin
      hold_done <= 1'b1;
      hold_off_cycles <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      m_axis_tready <= (recv_gap == 0);
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= (recv_gap == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input ppe_pkg::cfg_reg_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ppe_pkg::REG_ALPHA:     alpha_q = value[4:0];
      ppe_pkg::REG_TWO_ROOT:  root_q = value;
      ppe_pkg::REG_THRESHOLD: thresh_q = value;
      ppe_pkg::REG_OFFSET_EN: off_en_q = value[0];
      ppe_pkg::REG_LAMBDA_EN: lam_en_q = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || s_axis_tvalid || expected_energy.size() > 0)
      @(posedge clk_i);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
  endtask

  // Random pair, mostly near the well so the energy stays representable.
  function automatic pair_t random_pair();
    pair_t p;
    logic [63:0] sg, rr;
    p.sg = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(1 << 23, 1 << 26));
    sg = p.sg;
    rr = sg * $urandom_range(70, 300) / 100;
    if (rr == 0) rr = 1;
    p.d2 = ($urandom_range(0, 9) == 0) ? 48'({$urandom(), $urandom()})
                                       : 48'((rr * rr) >> 16);
    if ($urandom_range(0, 19) == 0) p.d2 = 0;
    p.eps = ($urandom_range(0, 4) == 0) ? $urandom() : 32'($signed($urandom_range(0, 1 << 20))
            - (1 << 19));
    p.off = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 1 << 24);
    p.lam = ($urandom_range(0, 9) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 30));
    return p;
  endfunction

  function automatic pair_t make_pair(input logic [47:0] d2, input logic [31:0] sg,
                                      input logic [31:0] eps, input logic [31:0] off,
                                      input logic [30:0] lam);
    pair_t p;
    p.d2 = d2; p.sg = sg; p.eps = eps; p.off = off; p.lam = lam;
    return p;
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items at reset settings: zero distance, field extremes, overflow.
    pending_pairs.push_back(make_pair(48'd0, 32'h0100_0000, 32'h0001_0000, '0, 31'h4000_0000));
    pending_pairs.push_back(make_pair('1, '1, 32'h8000_0000, '1, '1));
    pending_pairs.push_back(make_pair(48'd1, '1, 32'h7FFF_FFFF, '0, '0));
    pending_pairs.push_back(make_pair(48'h1_0000_0000, 32'h0100_0000, 32'h0001_0000, '0, '0));
    pending_pairs.push_back(make_pair(48'h1_0000_0000, 32'h0100_0000, '0, '0, '0));
    pending_pairs.push_back(make_pair(48'h1_6000_0000, 32'h0100_0000, 32'hFFFF_0000, '0, '0));
    pending_pairs.push_back(make_pair(48'h4_0000_0000, '0, 32'h0001_0000, '0, '0));
    drain();

    // Phases over register settings, extremes included.
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(ppe_pkg::REG_ALPHA, phase == 0 ? 32'd0 : phase == 1 ? 32'd1 :
                phase == 2 ? 32'd24 : phase == 3 ? 32'd31 : 32'($urandom_range(1, 24)));
      write_reg(ppe_pkg::REG_TWO_ROOT, phase == 1 ? 32'h8000_0000 :
                phase == 2 ? 32'h4000_0000 : phase == 3 ? 32'hFFFF_FFFF :
                32'($urandom_range(32'h4000_0000, 32'h8000_0000)));
      write_reg(ppe_pkg::REG_THRESHOLD, phase == 2 ? 32'hFFFF_FFFF :
                phase == 4 ? 32'h0040_0000 : phase[0] ? 32'd0 : 32'($urandom_range(0, 1 << 24)));
      write_reg(ppe_pkg::REG_OFFSET_EN, 32'(phase[1]));
      write_reg(ppe_pkg::REG_LAMBDA_EN, 32'(phase[0] | phase[2]));
      // Lambda above one and offset edge cases, sent in every phase.
      pending_pairs.push_back(make_pair(48'h1_0000_0000, 32'h0100_0000, 32'h0001_0000,
                                        32'h0080_0000, 31'h7FFF_FFFF));
      pending_pairs.push_back(make_pair(48'h0_4000_0000, 32'h0100_0000, 32'hFFFF_0000,
                                        '1, 31'h4000_0000));
      pending_pairs.push_back(make_pair(48'h9_0000_0000, 32'h0100_0000, 32'h7FFF_FFFF,
                                        '0, 31'h2000_0000));
      for (int n = 0; n < 165; n++) pending_pairs.push_back(random_pair());
      drain();
    end

    $display("Checked %0d result items over 9 register settings (%0d hard core, %0d saturated).",
             checked_count, hard_count, sat_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ppe_pkg.sv
rtl/ppe_isqrt.sv
rtl/ppe_div.sv
rtl/pair_potential_energy_unit.sv
tb/pair_potential_energy_unit_test.sv
